/* design/gle_pkg.sv */
// Package for the GIF LZW encoder: payload structs, controller commands and status,
// and the fixed codes shared by the controller and datapath.
// No dependencies.
package gle_pkg;

    localparam int GLE_EPOCH_W = 4;

    localparam logic [1:0] ACT_PIXEL     = 2'd0;
    localparam logic [1:0] ACT_PIXEL_END = 2'd1;
    localparam logic [1:0] ACT_END       = 2'd2;
    localparam logic [1:0] ACT_NONE      = 2'd3;

    localparam logic [1:0] CSEL_CLEAR  = 2'd0;
    localparam logic [1:0] CSEL_EOI    = 2'd1;
    localparam logic [1:0] CSEL_PREFIX = 2'd2;
    localparam logic [1:0] CSEL_TAIL   = 2'd3;

    localparam logic [1:0] OSEL_MCS  = 2'd0;
    localparam logic [1:0] OSEL_LEN  = 2'd1;
    localparam logic [1:0] OSEL_BUF  = 2'd2;
    localparam logic [1:0] OSEL_ZERO = 2'd3;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] symbol;
    } gle_in_t;

    typedef struct packed {
        logic [63:0] out_bytes;
        logic [3:0]  byte_count;
        logic        last;
        logic        frame_done;
    } gle_out_t;

    typedef struct packed {
        logic       latch_in;
        logic       frame_init;
        logic       frame_open;
        logic       frame_end;
        logic       set_prefix_sym;
        logic       set_prefix_hit;
        logic       ec_load;
        logic [1:0] code_sel;
        logic       ec_shift;
        logic       ec_store;
        logic       out_put;
        logic [1:0] out_sel;
        logic       fl_first;
        logic       buf_rd;
        logic       rd_next;
        logic       fill_clear;
        logic       lk_start;
        logic       lk_next;
        logic       insert;
        logic       tbl_clear;
        logic       sweep_wr;
        logic       fin;
        logic       fin_done;
    } gle_cmd_t;

    typedef struct packed {
        logic       in_frame;
        logic [1:0] action;
        logic       cnt_ge8;
        logic       fill_last;
        logic       fill_zero;
        logic       rd_last;
        logic       lk_hit;
        logic       lk_empty;
        logic       tbl_full;
        logic       epoch_wrap;
        logic       sweep_last;
    } gle_sts_t;

    typedef struct packed {
        logic byte_ready;
        logic fin_ready;
    } gle_pk_sts_t;

endpackage

/* design/gle_dpath.sv */
// Datapath of the GIF LZW encoder: string table as a hashed memory with epoch marks,
// code bit packer, sub-block buffer memory and the byte source for the output packer.
// Depends on gle_pkg.
module gle_dpath #(
    parameter int MAX_CODE_BITS = 12,
    parameter int DICT_CODES    = 4096,
    parameter int BLOCK_MAX     = 255
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [3:0]        cfg_wr_data,
    input  gle_pkg::gle_in_t  in_data,
    input  gle_pkg::gle_cmd_t cmd,
    output gle_pkg::gle_sts_t sts,
    output logic              byte_valid,
    output logic [7:0]        byte_data
);
    import gle_pkg::*;

    localparam int MCB    = MAX_CODE_BITS;
    localparam int KEY_W  = MCB + 8;
    localparam int HB     = $clog2(DICT_CODES) + 1;
    localparam int HDEPTH = 1 << HB;
    localparam int ENT_W  = 1 + GLE_EPOCH_W + KEY_W + MCB;
    localparam int AW     = MCB + 7;
    localparam int FILL_W = $clog2(BLOCK_MAX + 1);
    localparam int IDX_W  = (BLOCK_MAX > 1) ? $clog2(BLOCK_MAX) : 1;

    logic [3:0]             mcs_cfg_reg;
    logic [3:0]             frame_mcs_reg;
    logic [1:0]             action_reg;
    logic [7:0]             sym_reg;
    logic [MCB-1:0]         prefix_reg;
    logic [MCB:0]           nfc_reg;
    logic [3:0]             cw_reg;
    logic [7:0]             pend_reg;
    logic [2:0]             pc_reg;
    logic [AW-1:0]          acc_reg;
    logic [4:0]             cnt_reg;
    logic [FILL_W-1:0]      fill_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic                   in_frame_reg;
    logic [GLE_EPOCH_W-1:0] epoch_reg;
    logic [HB-1:0]          probe_reg;
    logic [HB-1:0]          sweep_reg;
    logic [ENT_W-1:0]       hrd_reg;
    logic [7:0]             brd_reg;

    logic [ENT_W-1:0] hmem [HDEPTH];
    logic [7:0]       bmem [BLOCK_MAX];

    logic [7:0]       sym_mask;
    logic [7:0]       sym_m;
    logic [MCB-1:0]   clear_code;
    logic [MCB-1:0]   code;
    logic [KEY_W-1:0] key;
    logic [HB-1:0]    hash_idx;
    logic [HB-1:0]    hraddr;
    logic             hre;
    logic             hwe;
    logic [HB-1:0]    hwaddr;
    logic [ENT_W-1:0] hwdata;
    logic             ent_valid;
    logic [3:0]       mcs_clamped;

    assign sym_mask   = 8'((9'd1 << frame_mcs_reg) - 9'd1);
    assign sym_m      = sym_reg & sym_mask;
    assign clear_code = MCB'(1) << frame_mcs_reg;
    assign key        = {prefix_reg, sym_m};
    assign hash_idx   = HB'(prefix_reg) ^ (HB'(sym_m) << (HB - 8));

    always_comb
    begin
        case (cmd.code_sel)
            CSEL_CLEAR:  code = clear_code;
            CSEL_EOI:    code = clear_code + MCB'(1);
            default:     code = prefix_reg;
        endcase
    end

    always_comb
    begin
        if (cfg_wr_data < 4'd2)
        begin
            mcs_clamped = 4'd2;
        end
        else if (cfg_wr_data > 4'd8)
        begin
            mcs_clamped = 4'd8;
        end
        else
        begin
            mcs_clamped = cfg_wr_data;
        end
    end

    assign hre    = cmd.lk_start || cmd.lk_next;
    assign hraddr = cmd.lk_start ? hash_idx : probe_reg + HB'(1);
    assign hwe    = cmd.sweep_wr || cmd.insert;
    assign hwaddr = cmd.sweep_wr ? sweep_reg : probe_reg;
    assign hwdata = cmd.sweep_wr ? '0 : {1'b1, epoch_reg, key, nfc_reg[MCB-1:0]};

    assign ent_valid = hrd_reg[ENT_W-1]
                    && (hrd_reg[ENT_W-2 -: GLE_EPOCH_W] == epoch_reg);

    always_ff @(posedge clk)
    begin
        if (hwe)
        begin
            hmem[hwaddr] <= hwdata;
        end
        if (hre)
        begin
            hrd_reg <= hmem[hraddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ec_shift)
        begin
            bmem[fill_reg[IDX_W-1:0]] <= acc_reg[7:0];
        end
        if (cmd.buf_rd)
        begin
            brd_reg <= bmem[rd_idx_reg];
        end
        if (cmd.latch_in)
        begin
            sym_reg <= in_data.symbol;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mcs_cfg_reg   <= 4'd8;
            frame_mcs_reg <= 4'd8;
            action_reg    <= ACT_NONE;
            prefix_reg    <= '0;
            nfc_reg       <= (MCB+1)'(258);
            cw_reg        <= 4'd9;
            pend_reg      <= '0;
            pc_reg        <= '0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            fill_reg      <= '0;
            rd_idx_reg    <= '0;
            in_frame_reg  <= 1'b0;
            epoch_reg     <= '0;
            probe_reg     <= '0;
            sweep_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mcs_cfg_reg <= mcs_clamped;
            end
            if (cmd.latch_in)
            begin
                action_reg <= in_data.action;
            end
            if (cmd.frame_init)
            begin
                frame_mcs_reg <= mcs_cfg_reg;
                nfc_reg       <= ((MCB+1)'(1) << mcs_cfg_reg) + (MCB+1)'(2);
                cw_reg        <= mcs_cfg_reg + 4'd1;
                epoch_reg     <= epoch_reg + GLE_EPOCH_W'(1);
                pend_reg      <= '0;
                pc_reg        <= '0;
                fill_reg      <= '0;
            end
            if (cmd.tbl_clear)
            begin
                nfc_reg   <= (MCB+1)'(clear_code) + (MCB+1)'(2);
                cw_reg    <= frame_mcs_reg + 4'd1;
                epoch_reg <= epoch_reg + GLE_EPOCH_W'(1);
            end
            if (cmd.insert)
            begin
                nfc_reg <= nfc_reg + (MCB+1)'(1);
                if (nfc_reg >= ((MCB+1)'(1) << cw_reg) && cw_reg < 4'(MCB))
                begin
                    cw_reg <= cw_reg + 4'd1;
                end
            end
            if (cmd.frame_open)
            begin
                in_frame_reg <= 1'b1;
            end
            if (cmd.frame_end)
            begin
                in_frame_reg <= 1'b0;
                pend_reg     <= '0;
                pc_reg       <= '0;
            end
            if (cmd.set_prefix_sym)
            begin
                prefix_reg <= MCB'(sym_m);
            end
            if (cmd.set_prefix_hit)
            begin
                prefix_reg <= hrd_reg[MCB-1:0];
            end
            if (cmd.ec_load)
            begin
                if (cmd.code_sel == CSEL_TAIL)
                begin
                    acc_reg <= AW'(pend_reg);
                    cnt_reg <= (pc_reg != 3'd0) ? 5'd8 : 5'd0;
                end
                else
                begin
                    acc_reg <= AW'(pend_reg) | (AW'(code) << pc_reg);
                    cnt_reg <= 5'(pc_reg) + 5'(cw_reg);
                end
            end
            if (cmd.ec_shift)
            begin
                acc_reg  <= acc_reg >> 8;
                cnt_reg  <= cnt_reg - 5'd8;
                fill_reg <= fill_reg + FILL_W'(1);
            end
            if (cmd.ec_store)
            begin
                pend_reg <= acc_reg[7:0];
                pc_reg   <= cnt_reg[2:0];
            end
            if (cmd.fl_first)
            begin
                rd_idx_reg <= '0;
            end
            if (cmd.rd_next)
            begin
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
            end
            if (cmd.fill_clear)
            begin
                fill_reg <= '0;
            end
            if (hre)
            begin
                probe_reg <= hraddr;
            end
            if (cmd.sweep_wr)
            begin
                sweep_reg <= sweep_reg + HB'(1);
            end
        end
    end

    always_comb
    begin
        case (cmd.out_sel)
            OSEL_MCS: byte_data = 8'(frame_mcs_reg);
            OSEL_LEN: byte_data = 8'(fill_reg);
            OSEL_BUF: byte_data = brd_reg;
            default:  byte_data = 8'h00;
        endcase
    end

    assign byte_valid = cmd.out_put;

    assign sts.in_frame   = in_frame_reg;
    assign sts.action     = action_reg;
    assign sts.cnt_ge8    = cnt_reg >= 5'd8;
    assign sts.fill_last  = (fill_reg + FILL_W'(1)) == FILL_W'(BLOCK_MAX);
    assign sts.fill_zero  = fill_reg == '0;
    assign sts.rd_last    = (FILL_W'(rd_idx_reg) + FILL_W'(1)) == fill_reg;
    assign sts.lk_hit     = ent_valid && (hrd_reg[MCB +: KEY_W] == key);
    assign sts.lk_empty   = !ent_valid;
    assign sts.tbl_full   = nfc_reg >= (MCB+1)'(DICT_CODES);
    assign sts.epoch_wrap = &epoch_reg;
    assign sts.sweep_last = &sweep_reg;

endmodule

/* design/gle_pack.sv */
// Output packer of the GIF LZW encoder: gathers the byte stream of one item into
// result beats of up to OUT_LANES bytes behind an output register.
// Depends on gle_pkg.
module gle_pack #(
    parameter int OUT_LANES = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    input  logic [7:0]           byte_data,
    input  gle_pkg::gle_cmd_t    cmd,
    output gle_pkg::gle_pk_sts_t pk_sts,
    output logic                 res_valid,
    input  logic                 res_ready,
    output gle_pkg::gle_out_t    res_data
);
    import gle_pkg::*;

    logic [63:0] buf_reg;
    logic [3:0]  cnt_reg;
    logic        res_valid_reg;
    gle_out_t    res_data_reg;
    logic        full;

    assign full              = cnt_reg == 4'(OUT_LANES);
    assign pk_sts.byte_ready = !full || !res_valid_reg;
    assign pk_sts.fin_ready  = (cnt_reg == 4'd0) || !res_valid_reg;

    always_ff @(posedge clk)
    begin
        if (byte_valid)
        begin
            if (full || cnt_reg == 4'd0)
            begin
                buf_reg <= 64'(byte_data);
            end
            else
            begin
                buf_reg[8*cnt_reg[2:0] +: 8] <= byte_data;
            end
        end
        if (byte_valid && full)
        begin
            res_data_reg <= '{out_bytes: buf_reg, byte_count: cnt_reg,
                              last: 1'b0, frame_done: 1'b0};
        end
        else if (cmd.fin && cnt_reg != 4'd0)
        begin
            res_data_reg <= '{out_bytes: buf_reg, byte_count: cnt_reg,
                              last: 1'b1, frame_done: cmd.fin_done};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (byte_valid)
            begin
                if (full)
                begin
                    res_valid_reg <= 1'b1;
                    cnt_reg       <= 4'd1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                end
            end
            else if (cmd.fin && cnt_reg != 4'd0)
            begin
                res_valid_reg <= 1'b1;
                cnt_reg       <= 4'd0;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

/* design/gle_ctrl.sv */
// Controller of the GIF LZW encoder: sequences frame start, table lookup and insert,
// code emission, sub-block flushes, frame close and the table clearing pass.
// Depends on gle_pkg.
module gle_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sym_valid,
    output logic                 sym_ready,
    input  gle_pkg::gle_sts_t    sts,
    input  gle_pkg::gle_pk_sts_t pk_sts,
    output gle_pkg::gle_cmd_t    cmd
);
    import gle_pkg::*;

    localparam logic [4:0] S_SWEEP     = 5'd0;
    localparam logic [4:0] S_IDLE      = 5'd1;
    localparam logic [4:0] S_DISPATCH  = 5'd2;
    localparam logic [4:0] S_FS_INIT   = 5'd3;
    localparam logic [4:0] S_FS_SIZE   = 5'd4;
    localparam logic [4:0] S_FS_CLR    = 5'd5;
    localparam logic [4:0] S_FS_SYM    = 5'd6;
    localparam logic [4:0] S_EMIT_PFX  = 5'd7;
    localparam logic [4:0] S_LK_CMP    = 5'd8;
    localparam logic [4:0] S_MISS      = 5'd9;
    localparam logic [4:0] S_CLR_TBL   = 5'd10;
    localparam logic [4:0] S_AFTER_SYM = 5'd11;
    localparam logic [4:0] S_CL_EOI    = 5'd12;
    localparam logic [4:0] S_CL_TAIL   = 5'd13;
    localparam logic [4:0] S_CL_FLUSH  = 5'd14;
    localparam logic [4:0] S_CL_TERM   = 5'd15;
    localparam logic [4:0] S_FIN       = 5'd16;
    localparam logic [4:0] S_EC_BYTE   = 5'd17;
    localparam logic [4:0] S_FL_LEN    = 5'd18;
    localparam logic [4:0] S_FL_RD     = 5'd19;
    localparam logic [4:0] S_FL_WR     = 5'd20;

    logic [4:0] state_reg, state_next;
    logic [4:0] ec_ret_reg, ec_ret_next;
    logic [4:0] fl_ret_reg, fl_ret_next;
    logic [4:0] sw_ret_reg, sw_ret_next;
    logic       done_reg, done_next;

    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        ec_ret_next = ec_ret_reg;
        fl_ret_next = fl_ret_reg;
        sw_ret_next = sw_ret_reg;
        done_next   = done_reg;
        case (state_reg)
            S_SWEEP:
            begin
                cmd.sweep_wr = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = sw_ret_reg;
                end
            end
            S_IDLE:
            begin
                if (sym_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (sts.action == ACT_NONE)
                begin
                    state_next = S_IDLE;
                end
                else if (!sts.in_frame)
                begin
                    state_next = S_FS_INIT;
                end
                else if (sts.action == ACT_END)
                begin
                    state_next = S_EMIT_PFX;
                end
                else
                begin
                    cmd.lk_start = 1'b1;
                    state_next   = S_LK_CMP;
                end
            end
            S_FS_INIT:
            begin
                cmd.frame_init = 1'b1;
                if (sts.epoch_wrap)
                begin
                    sw_ret_next = S_FS_SIZE;
                    state_next  = S_SWEEP;
                end
                else
                begin
                    state_next = S_FS_SIZE;
                end
            end
            S_FS_SIZE:
            begin
                if (pk_sts.byte_ready)
                begin
                    cmd.out_put = 1'b1;
                    cmd.out_sel = OSEL_MCS;
                    state_next  = S_FS_CLR;
                end
            end
            S_FS_CLR:
            begin
                cmd.ec_load  = 1'b1;
                cmd.code_sel = CSEL_CLEAR;
                ec_ret_next  = S_FS_SYM;
                state_next   = S_EC_BYTE;
            end
            S_FS_SYM:
            begin
                if (sts.action == ACT_END)
                begin
                    state_next = S_CL_EOI;
                end
                else
                begin
                    cmd.set_prefix_sym = 1'b1;
                    cmd.frame_open     = 1'b1;
                    state_next = (sts.action == ACT_PIXEL_END) ? S_EMIT_PFX : S_FIN;
                end
            end
            S_EMIT_PFX:
            begin
                cmd.ec_load  = 1'b1;
                cmd.code_sel = CSEL_PREFIX;
                ec_ret_next  = S_CL_EOI;
                state_next   = S_EC_BYTE;
            end
            S_LK_CMP:
            begin
                if (sts.lk_hit)
                begin
                    cmd.set_prefix_hit = 1'b1;
                    state_next = (sts.action == ACT_PIXEL_END) ? S_EMIT_PFX : S_FIN;
                end
                else if (sts.lk_empty)
                begin
                    cmd.ec_load  = 1'b1;
                    cmd.code_sel = CSEL_PREFIX;
                    ec_ret_next  = S_MISS;
                    state_next   = S_EC_BYTE;
                end
                else
                begin
                    cmd.lk_next = 1'b1;
                end
            end
            S_MISS:
            begin
                if (!sts.tbl_full)
                begin
                    cmd.insert         = 1'b1;
                    cmd.set_prefix_sym = 1'b1;
                    state_next         = S_AFTER_SYM;
                end
                else
                begin
                    cmd.ec_load  = 1'b1;
                    cmd.code_sel = CSEL_CLEAR;
                    ec_ret_next  = S_CLR_TBL;
                    state_next   = S_EC_BYTE;
                end
            end
            S_CLR_TBL:
            begin
                cmd.tbl_clear      = 1'b1;
                cmd.set_prefix_sym = 1'b1;
                if (sts.epoch_wrap)
                begin
                    sw_ret_next = S_AFTER_SYM;
                    state_next  = S_SWEEP;
                end
                else
                begin
                    state_next = S_AFTER_SYM;
                end
            end
            S_AFTER_SYM:
            begin
                state_next = (sts.action == ACT_PIXEL_END) ? S_EMIT_PFX : S_FIN;
            end
            S_CL_EOI:
            begin
                cmd.ec_load  = 1'b1;
                cmd.code_sel = CSEL_EOI;
                ec_ret_next  = S_CL_TAIL;
                state_next   = S_EC_BYTE;
            end
            S_CL_TAIL:
            begin
                cmd.ec_load  = 1'b1;
                cmd.code_sel = CSEL_TAIL;
                ec_ret_next  = S_CL_FLUSH;
                state_next   = S_EC_BYTE;
            end
            S_CL_FLUSH:
            begin
                fl_ret_next = S_CL_TERM;
                state_next  = S_FL_LEN;
            end
            S_CL_TERM:
            begin
                if (pk_sts.byte_ready)
                begin
                    cmd.out_put   = 1'b1;
                    cmd.out_sel   = OSEL_ZERO;
                    cmd.frame_end = 1'b1;
                    done_next     = 1'b1;
                    state_next    = S_FIN;
                end
            end
            S_FIN:
            begin
                if (pk_sts.fin_ready)
                begin
                    cmd.fin      = 1'b1;
                    cmd.fin_done = done_reg;
                    done_next    = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            S_EC_BYTE:
            begin
                if (sts.cnt_ge8)
                begin
                    cmd.ec_shift = 1'b1;
                    if (sts.fill_last)
                    begin
                        fl_ret_next = S_EC_BYTE;
                        state_next  = S_FL_LEN;
                    end
                end
                else
                begin
                    cmd.ec_store = 1'b1;
                    state_next   = ec_ret_reg;
                end
            end
            S_FL_LEN:
            begin
                if (sts.fill_zero)
                begin
                    state_next = fl_ret_reg;
                end
                else if (pk_sts.byte_ready)
                begin
                    cmd.out_put  = 1'b1;
                    cmd.out_sel  = OSEL_LEN;
                    cmd.fl_first = 1'b1;
                    state_next   = S_FL_RD;
                end
            end
            S_FL_RD:
            begin
                cmd.buf_rd = 1'b1;
                state_next = S_FL_WR;
            end
            S_FL_WR:
            begin
                if (pk_sts.byte_ready)
                begin
                    cmd.out_put = 1'b1;
                    cmd.out_sel = OSEL_BUF;
                    if (sts.rd_last)
                    begin
                        cmd.fill_clear = 1'b1;
                        state_next     = fl_ret_reg;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                        state_next  = S_FL_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_SWEEP;
            ec_ret_reg <= S_IDLE;
            fl_ret_reg <= S_IDLE;
            sw_ret_reg <= S_IDLE;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ec_ret_reg <= ec_ret_next;
            fl_ret_reg <= fl_ret_next;
            sw_ret_reg <= sw_ret_next;
            done_reg   <= done_next;
        end
    end

    assign sym_ready = state_reg == S_IDLE;

    // The packer must have room for every byte and every end of item it is handed.
    a_byte_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_put |-> pk_sts.byte_ready)
        else $error("byte pushed while packer full");

    a_fin_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |-> pk_sts.fin_ready)
        else $error("item closed while output register busy");

    // An accepted beat is always dispatched in the following cycle.
    a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (sym_valid && sym_ready) |=> (state_reg == S_DISPATCH))
        else $error("accepted beat not dispatched");

    // A frame-done result is only flagged after the terminator byte was sent.
    a_done_term: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fin && cmd.fin_done) |-> $past(state_reg == S_CL_TERM || state_reg == S_FIN))
        else $error("frame done without terminator");

endmodule

/* design/gif_lzw_encoder.sv */
// GIF LZW encoder top level. A pixel that extends the current string takes a hash lookup plus
// any extra probes; a miss adds the prefix code bytes and an insert, a table clear its clear
// code bytes. A sub-block flush sends the length byte, then each buffered byte. Frame start sends
// the code size and clear code, frame close the EOI code, tail and terminator. One item is worked
// at a time and the controller sequence sets the rate. Reset clears all control state, then a pass
// clearing the 2*DICT_CODES entries runs before the first item and on each sixteenth table reset.
module gif_lzw_encoder #(
    parameter int MAX_CODE_BITS = 12,
    parameter int DICT_CODES    = 4096,
    parameter int BLOCK_MAX     = 255,
    parameter int OUT_LANES     = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [3:0]        cfg_wr_data,
    input  logic              sym_valid,
    output logic              sym_ready,
    input  gle_pkg::gle_in_t  sym_data,
    output logic              res_valid,
    input  logic              res_ready,
    output gle_pkg::gle_out_t res_data
);
    import gle_pkg::*;

    gle_cmd_t    cmd;
    gle_sts_t    sts;
    gle_pk_sts_t pk_sts;
    logic        byte_valid;
    logic [7:0]  byte_data;

    gle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (sym_valid),
        .sym_ready (sym_ready),
        .sts       (sts),
        .pk_sts    (pk_sts),
        .cmd       (cmd)
    );

    gle_dpath #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .DICT_CODES    (DICT_CODES),
        .BLOCK_MAX     (BLOCK_MAX)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (sym_data),
        .cmd         (cmd),
        .sts         (sts),
        .byte_valid  (byte_valid),
        .byte_data   (byte_data)
    );

    gle_pack #(
        .OUT_LANES (OUT_LANES)
    ) u_pack (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .cmd        (cmd),
        .pk_sts     (pk_sts),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_data   (res_data)
    );

endmodule
